// ===== rtl/qrs_pkg.sv =====
// Shared widths, class codes and cell data types for the quadratic root solver.
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;

  localparam int CW         = 16;           // coefficient width
  localparam int PW         = 2 * CW;       // product width
  localparam int DW         = PW + 2;       // discriminant width
  localparam int RADW       = DW + 32;      // radicand: discriminant with 32 extra fraction bits
  localparam int ROOTW      = RADW / 2;     // square root width
  localparam int REMW       = ROOTW + 1;    // sqrt partial remainder width
  localparam int SQRT_STEPS = ROOTW;
  localparam int NUMW       = ROOTW + 1;    // numerator magnitude width
  localparam int DENW       = CW + 1;       // divisor magnitude width
  localparam int DIV_STEPS  = NUMW;
  localparam int OUTW       = 32;
  localparam int CLSW       = 3;

  localparam logic [CLSW-1:0] CLS_INF    = 3'd0;
  localparam logic [CLSW-1:0] CLS_NONE   = 3'd1;
  localparam logic [CLSW-1:0] CLS_NOREAL = 3'd2;
  localparam logic [CLSW-1:0] CLS_DOUBLE = 3'd3;
  localparam logic [CLSW-1:0] CLS_TWO    = 3'd4;
  localparam logic [CLSW-1:0] CLS_LIN    = 3'd5;

  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
    logic [CLSW-1:0]      cls;
  } side_t;

  typedef struct packed {
    logic [RADW-1:0]  rad;
    logic [REMW-1:0]  rem;
    logic [ROOTW-1:0] root;
    side_t            side;
  } sqrt_t;

  typedef struct packed {
    logic [DENW-1:0] den;
    logic [NUMW-1:0] q1;
    logic [DENW-1:0] r1;
    logic            neg1;
    logic [NUMW-1:0] q2;
    logic [DENW-1:0] r2;
    logic            neg2;
    logic [CLSW-1:0] cls;
  } div_t;

endpackage
`default_nettype wire

// ===== rtl/quadratic_root_solver_unit.sv =====
// Top level: coefficient products, sqrt cell row, divider cell row and saturation.
//
//  channel | dir | ports
//  --------+-----+-----------------------------------------------------------
//  input   | in  | in_valid, in_stall, in_coef_a, in_coef_b, in_coef_c
//  result  | out | out_valid, out_stall, out_root_class, out_root_first,
//          |     | out_root_second
//
// One equation enters per cycle unless stalled; the pipeline is the 33-cell
// square root row and the 34-cell divider row plus four boundary registers.
// rst_n clears every valid bit; data registers are not reset.
// A stalled result held in the output register freezes the whole row, and
// in_stall rises in that cycle; otherwise a new transfer is taken each cycle.
`timescale 1ns / 1ps
`default_nettype none
module quadratic_root_solver_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [qrs_pkg::CW-1:0] in_coef_a,
  input  wire logic signed [qrs_pkg::CW-1:0] in_coef_b,
  input  wire logic signed [qrs_pkg::CW-1:0] in_coef_c,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [qrs_pkg::CLSW-1:0]           out_root_class,
  output logic signed [qrs_pkg::OUTW-1:0]    out_root_first,
  output logic signed [qrs_pkg::OUTW-1:0]    out_root_second
);

  logic adv;

  logic                          va_r;
  logic signed [qrs_pkg::CW-1:0] a_r, b_r, c_r;
  logic                          vb_r;
  logic [qrs_pkg::PW-1:0]        bb_r, ac_r;
  qrs_pkg::side_t                sb_r;
  logic [qrs_pkg::CW-1:0]        ma, mb, mc;

  logic                          sq_v [0:qrs_pkg::SQRT_STEPS];
  qrs_pkg::sqrt_t                sq_d [0:qrs_pkg::SQRT_STEPS];
  logic                          dv_v [0:qrs_pkg::DIV_STEPS];
  qrs_pkg::div_t                 dv_d [0:qrs_pkg::DIV_STEPS];

  logic [qrs_pkg::DW-1:0]        bb34, ac4, dsc;
  logic                          ac_neg;
  logic [qrs_pkg::CLSW-1:0]      cls_c;

  qrs_pkg::side_t                ps;
  logic signed [qrs_pkg::NUMW:0] bx, cx, nb, nc, sx, n1, n2;
  logic [qrs_pkg::NUMW:0]        m1, m2;
  logic signed [qrs_pkg::DENW-1:0] dn;
  qrs_pkg::div_t                 p_nxt;
  logic                          vp_r;
  qrs_pkg::div_t                 p_r;

  logic                          out_valid_r;
  logic [qrs_pkg::CLSW-1:0]      cls_r;
  logic [qrs_pkg::OUTW-1:0]      first_r, second_r;
  logic [qrs_pkg::OUTW-1:0]      first_nxt, second_nxt;
  qrs_pkg::div_t                 fd;

  function automatic logic [qrs_pkg::OUTW-1:0] sat_root(input logic [qrs_pkg::NUMW-1:0] q,
                                                        input logic neg);
    logic [qrs_pkg::OUTW-1:0] r;
    if (neg) begin
      if (q > qrs_pkg::NUMW'(64'h8000_0000)) r = 32'h8000_0000;
      else r = qrs_pkg::OUTW'(~q + 1'b1);
    end else begin
      if (q > qrs_pkg::NUMW'(64'h7FFF_FFFF)) r = 32'h7FFF_FFFF;
      else r = q[qrs_pkg::OUTW-1:0];
    end
    return r;
  endfunction

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r <= in_coef_a;
      b_r <= in_coef_b;
      c_r <= in_coef_c;
    end
  end

  // magnitude products
  always_comb begin
    ma = a_r[qrs_pkg::CW-1] ? qrs_pkg::CW'(-a_r) : a_r;
    mb = b_r[qrs_pkg::CW-1] ? qrs_pkg::CW'(-b_r) : b_r;
    mc = c_r[qrs_pkg::CW-1] ? qrs_pkg::CW'(-c_r) : c_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bb_r     <= mb * mb;
      ac_r     <= ma * mc;
      sb_r.a   <= a_r;
      sb_r.b   <= b_r;
      sb_r.c   <= c_r;
      sb_r.cls <= qrs_pkg::CLS_INF;
    end
  end

  // discriminant and class
  always_comb begin
    bb34   = qrs_pkg::DW'(bb_r);
    ac4    = {ac_r, 2'b00};
    ac_neg = (sb_r.a[qrs_pkg::CW-1] != sb_r.c[qrs_pkg::CW-1]) && (sb_r.c != '0);
    dsc    = '0;
    if (sb_r.a == '0) begin
      if (sb_r.b == '0) begin
        cls_c = (sb_r.c == '0) ? qrs_pkg::CLS_INF : qrs_pkg::CLS_NONE;
      end else begin
        cls_c = qrs_pkg::CLS_LIN;
      end
    end else if (ac_neg) begin
      cls_c = qrs_pkg::CLS_TWO;
      dsc   = bb34 + ac4;
    end else if (bb34 > ac4) begin
      cls_c = qrs_pkg::CLS_TWO;
      dsc   = bb34 - ac4;
    end else if (bb34 == ac4) begin
      cls_c = qrs_pkg::CLS_DOUBLE;
    end else begin
      cls_c = qrs_pkg::CLS_NOREAL;
    end
    sq_v[0]          = vb_r;
    sq_d[0].rad      = {dsc, 32'd0};
    sq_d[0].rem      = '0;
    sq_d[0].root     = '0;
    sq_d[0].side     = sb_r;
    sq_d[0].side.cls = cls_c;
  end

  for (genvar k = 0; k < qrs_pkg::SQRT_STEPS; k++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .v_in  (sq_v[k]),
      .d_in  (sq_d[k]),
      .v_out (sq_v[k+1]),
      .d_out (sq_d[k+1])
    );
  end

  // numerators and divisor
  always_comb begin
    ps = sq_d[qrs_pkg::SQRT_STEPS].side;
    bx = (qrs_pkg::NUMW+1)'(ps.b);
    cx = (qrs_pkg::NUMW+1)'(ps.c);
    nb = -(bx <<< 16);
    nc = -(cx <<< 16);
    sx = $signed({2'b00, sq_d[qrs_pkg::SQRT_STEPS].root});
    n1 = '0;
    n2 = '0;
    dn = {ps.a, 1'b0};
    case (ps.cls)
      qrs_pkg::CLS_LIN: begin
        n1 = nc;
        dn = qrs_pkg::DENW'(ps.b);
      end
      qrs_pkg::CLS_DOUBLE: begin
        n1 = nb;
      end
      qrs_pkg::CLS_TWO: begin
        n1 = nb + sx;
        n2 = nb - sx;
      end
      default: begin
        n1 = '0;
      end
    endcase
    m1 = n1[qrs_pkg::NUMW] ? (qrs_pkg::NUMW+1)'(-n1) : n1;
    m2 = n2[qrs_pkg::NUMW] ? (qrs_pkg::NUMW+1)'(-n2) : n2;
    p_nxt.den  = dn[qrs_pkg::DENW-1] ? qrs_pkg::DENW'(-dn) : dn;
    p_nxt.q1   = m1[qrs_pkg::NUMW-1:0];
    p_nxt.r1   = '0;
    p_nxt.neg1 = n1[qrs_pkg::NUMW] ^ dn[qrs_pkg::DENW-1];
    p_nxt.q2   = m2[qrs_pkg::NUMW-1:0];
    p_nxt.r2   = '0;
    p_nxt.neg2 = n2[qrs_pkg::NUMW] ^ dn[qrs_pkg::DENW-1];
    p_nxt.cls  = ps.cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else if (adv) begin
      vp_r <= sq_v[qrs_pkg::SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r <= p_nxt;
    end
  end

  assign dv_v[0] = vp_r;
  assign dv_d[0] = p_r;

  for (genvar k = 0; k < qrs_pkg::DIV_STEPS; k++) begin : g_div
    qrs_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .v_in  (dv_v[k]),
      .d_in  (dv_d[k]),
      .v_out (dv_v[k+1]),
      .d_out (dv_d[k+1])
    );
  end

  // sign, saturation and class masking
  always_comb begin
    fd         = dv_d[qrs_pkg::DIV_STEPS];
    first_nxt  = '0;
    second_nxt = '0;
    if (fd.cls == qrs_pkg::CLS_DOUBLE || fd.cls == qrs_pkg::CLS_TWO ||
        fd.cls == qrs_pkg::CLS_LIN) begin
      first_nxt = sat_root(fd.q1, fd.neg1);
    end
    if (fd.cls == qrs_pkg::CLS_TWO) begin
      second_nxt = sat_root(fd.q2, fd.neg2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_v[qrs_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cls_r    <= fd.cls;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_root_class  = cls_r;
  assign out_root_first  = $signed(first_r);
  assign out_root_second = $signed(second_r);

endmodule
`default_nettype wire

// ===== rtl/qrs_sqrt_cell.sv =====
// One digit of the pipelined square root: one result bit per cell.
`timescale 1ns / 1ps
`default_nettype none
module qrs_sqrt_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          v_in,
  input  wire qrs_pkg::sqrt_t d_in,
  output logic               v_out,
  output qrs_pkg::sqrt_t     d_out
);

  logic [qrs_pkg::REMW+1:0]  rsh;
  logic [qrs_pkg::ROOTW+1:0] trial;
  logic                      ge;
  qrs_pkg::sqrt_t            d_nxt;
  logic                      v_r;
  qrs_pkg::sqrt_t            d_r;

  always_comb begin
    rsh   = {d_in.rem, d_in.rad[qrs_pkg::RADW-1 -: 2]};
    trial = {d_in.root, 2'b01};
    ge    = (rsh >= {1'b0, trial});
    d_nxt      = d_in;
    d_nxt.rad  = {d_in.rad[qrs_pkg::RADW-3:0], 2'b00};
    if (ge) begin
      d_nxt.rem = qrs_pkg::REMW'(rsh - {1'b0, trial});
    end else begin
      d_nxt.rem = rsh[qrs_pkg::REMW-1:0];
    end
    d_nxt.root = {d_in.root[qrs_pkg::ROOTW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign v_out = v_r;
  assign d_out = d_r;

endmodule
`default_nettype wire

// ===== rtl/qrs_div_cell.sv =====
// One quotient bit of both restoring dividers, sharing the divisor.
`timescale 1ns / 1ps
`default_nettype none
module qrs_div_cell (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         v_in,
  input  wire qrs_pkg::div_t d_in,
  output logic              v_out,
  output qrs_pkg::div_t     d_out
);

  logic [qrs_pkg::DENW:0] rsh1;
  logic [qrs_pkg::DENW:0] rsh2;
  logic                   ge1;
  logic                   ge2;
  qrs_pkg::div_t          d_nxt;
  logic                   v_r;
  qrs_pkg::div_t          d_r;

  always_comb begin
    rsh1 = {d_in.r1, d_in.q1[qrs_pkg::NUMW-1]};
    rsh2 = {d_in.r2, d_in.q2[qrs_pkg::NUMW-1]};
    ge1  = (rsh1 >= {1'b0, d_in.den});
    ge2  = (rsh2 >= {1'b0, d_in.den});
    d_nxt = d_in;
    d_nxt.r1 = ge1 ? qrs_pkg::DENW'(rsh1 - {1'b0, d_in.den}) : rsh1[qrs_pkg::DENW-1:0];
    d_nxt.r2 = ge2 ? qrs_pkg::DENW'(rsh2 - {1'b0, d_in.den}) : rsh2[qrs_pkg::DENW-1:0];
    // dividend bits shift out at the top while quotient bits shift in below
    d_nxt.q1 = {d_in.q1[qrs_pkg::NUMW-2:0], ge1};
    d_nxt.q2 = {d_in.q2[qrs_pkg::NUMW-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign v_out = v_r;
  assign d_out = d_r;

endmodule
`default_nettype wire
